@@ rtl/core/vhmt_pkg.sv @@
// shared constants, codes and word types for the versioned hash memo table
package vhmt_pkg;

   localparam int TABLE_SLOTS_DEF = 4096;
   localparam int MAX_PROBES_DEF  = 32;

   // multiplicative hash
   localparam int          HASH_W   = 32;
   localparam int          KEY_DROP = 4;
   localparam logic [31:0] HASH_MUL = 32'd2654435761;

   // action codes
   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_STORE  = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // lookup answer codes
   localparam logic [1:0] ANS_UNKNOWN = 2'd0;
   localparam logic [1:0] ANS_FALSE   = 2'd1;
   localparam logic [1:0] ANS_TRUE    = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] item_key;
      logic [31:0] item_version;
      logic [31:0] current_epoch;
      logic        answer_bit;
   } req_type;

   typedef struct packed {
      logic [1:0] lookup_answer;
      logic       store_done;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic req_load;
      logic hash;
      logic rem_step;
      logic slot_load;
      logic rd_issue;
      logic probe_next;
      logic res_lookup;
      logic mem_write;
      logic clr_write;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       key_zero;
      logic       rem_last;
      logic       clr_last;
      logic       slot_empty;
      logic       key_match;
      logic       epoch_stale;
      logic       probe_last;
   } sts_type;

endpackage

@@ rtl/core/vhmt_dpath.sv @@
// datapath: request register, hash and slot reduction, probe walk, slot memory, result
module vhmt_dpath #(
   parameter int TABLE_SLOTS = vhmt_pkg::TABLE_SLOTS_DEF,
   parameter int MAX_PROBES  = vhmt_pkg::MAX_PROBES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  vhmt_pkg::req_type req_word,
   input  vhmt_pkg::cmd_type cmd,
   output vhmt_pkg::sts_type sts,
   output vhmt_pkg::rsp_type rsp_word
);
   import vhmt_pkg::*;

   localparam int  SLOT_W  = $clog2(TABLE_SLOTS);
   localparam int  PROBE_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
   localparam bit  IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
   // reciprocal reduction of the 32-bit hash for other sizes: quotient
   // estimate, multiply back, then one compare and subtract
   localparam int  RCNT_W  = 2;
   localparam logic [RCNT_W-1:0] RED_RECIP = 2'd2;
   localparam logic [RCNT_W-1:0] RED_BACK  = 2'd1;
   localparam logic [HASH_W-1:0] SLOTS_H   = HASH_W'(TABLE_SLOTS);
   localparam logic [HASH_W-1:0] RECIP     = HASH_W'(64'h1_0000_0000 / 64'(TABLE_SLOTS));
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

   typedef struct packed {
      logic [63:0] slot_key;
      logic [31:0] slot_epoch;
      logic [31:0] slot_version;
      logic        slot_answer;
   } entry_type;

   req_type             req_ff, req_in;
   logic [HASH_W-1:0]   rem_ff, rem_in;
   logic [HASH_W-1:0]   quo_ff, quo_in;
   logic [RCNT_W-1:0]   rcnt_ff, rcnt_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [PROBE_W-1:0]  probe_ff, probe_in;
   logic [SLOT_W-1:0]   clr_addr_ff, clr_addr_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_word_ff, rsp_word_in;
   entry_type           rd_data_ff;
   entry_type           mem_ff [TABLE_SLOTS];

   logic [HASH_W-1:0]   hash_prod;
   logic [2*HASH_W-1:0] recip_prod;
   logic [HASH_W-1:0]   quo_back;
   logic [HASH_W-1:0]   rem_fix;
   logic [HASH_W-1:0]   rem_sel;
   logic [SLOT_W-1:0]   slot_inc;
   logic [SLOT_W-1:0]   rd_addr;
   logic [SLOT_W-1:0]   wr_addr;
   entry_type           wr_data;
   logic                wr_en;
   logic                rd_en;

   assign hash_prod  = req_ff.item_key[KEY_DROP +: HASH_W] * HASH_MUL;
   // estimate is the true quotient or one less, so the remainder stays below 2 slots
   assign recip_prod = rem_ff * RECIP;
   assign quo_back   = quo_ff * SLOTS_H;
   assign rem_fix    = (rem_ff >= SLOTS_H) ? (rem_ff - SLOTS_H) : rem_ff;
   assign rem_sel    = IS_POW2 ? rem_ff : rem_fix;
   assign slot_inc   = (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;

   always_comb begin
      req_in      = req_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      rcnt_in     = rcnt_ff;
      slot_in     = slot_ff;
      probe_in    = probe_ff;
      clr_addr_in = clr_addr_ff;
      res_in      = res_ff;
      rsp_word_in = rsp_word_ff;

      if (cmd.req_load) begin
         req_in = req_word;
      end
      if (cmd.hash) begin
         rem_in  = hash_prod;
         rcnt_in = RED_RECIP;
         res_in  = '0;
      end
      if (cmd.rem_step) begin
         rcnt_in = rcnt_ff - 1'b1;
         if (rcnt_ff == RED_RECIP) begin
            quo_in = recip_prod[2*HASH_W-1:HASH_W];
         end
         if (rcnt_ff == RED_BACK) begin
            rem_in = rem_ff - quo_back;
         end
      end
      if (cmd.slot_load) begin
         slot_in  = rem_sel[SLOT_W-1:0];
         probe_in = '0;
      end
      if (cmd.probe_next) begin
         slot_in  = slot_inc;
         probe_in = probe_ff + 1'b1;
      end
      if (cmd.res_lookup) begin
         if (rd_data_ff.slot_epoch == req_ff.current_epoch
             && rd_data_ff.slot_version == req_ff.item_version) begin
            res_in.lookup_answer = rd_data_ff.slot_answer ? ANS_TRUE : ANS_FALSE;
         end else begin
            res_in.lookup_answer = ANS_UNKNOWN;
         end
      end
      if (cmd.mem_write) begin
         res_in.store_done = 1'b1;
      end
      if (cmd.clr_write) begin
         clr_addr_in = (clr_addr_ff == SLOT_LAST) ? '0 : clr_addr_ff + 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_word_in = res_ff;
      end
   end

   // memory ports
   always_comb begin
      rd_en   = cmd.rd_issue || cmd.probe_next;
      rd_addr = cmd.probe_next ? slot_inc : slot_ff;
      wr_en   = cmd.mem_write || cmd.clr_write;
      wr_addr = cmd.clr_write ? clr_addr_ff : slot_ff;
      wr_data = '0;
      if (!cmd.clr_write) begin
         wr_data.slot_key     = req_ff.item_key;
         wr_data.slot_epoch   = req_ff.current_epoch;
         wr_data.slot_version = req_ff.item_version;
         wr_data.slot_answer  = req_ff.answer_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff    <= '0;
         clr_addr_ff <= '0;
      end else begin
         probe_ff    <= probe_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rcnt_ff     <= rcnt_in;
      slot_ff     <= slot_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      sts.op          = req_ff.action;
      sts.key_zero    = (req_ff.item_key == '0);
      sts.rem_last    = IS_POW2 || (rcnt_ff == '0);
      sts.clr_last    = (clr_addr_ff == SLOT_LAST);
      sts.slot_empty  = (rd_data_ff.slot_key == '0);
      sts.key_match   = (rd_data_ff.slot_key == req_ff.item_key);
      sts.epoch_stale = (rd_data_ff.slot_epoch != req_ff.current_epoch);
      sts.probe_last  = (probe_ff == PROBE_W'(MAX_PROBES - 1));
   end

   assign rsp_word = rsp_word_ff;

`ifndef NO_ASSERTIONS
   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      probe_ff <= PROBE_W'(MAX_PROBES - 1))
      else $error("probe count past the probe limit");
`endif

endmodule

@@ rtl/core/vhmt_ctrl.sv @@
// controller: sequences clear sweep, hashing, probe walk and result handoff
module vhmt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  vhmt_pkg::sts_type sts,
   output vhmt_pkg::cmd_type cmd
);
   import vhmt_pkg::*;

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_HASH   = 3'd2;
   localparam logic [2:0] S_REDUCE = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_CHECK  = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       clr_req_ff, clr_req_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      clr_req_in   = clr_req_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (sts.clr_last) begin
               clr_req_in = 1'b0;
               state_in   = clr_req_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_HASH;
            end
         end
         S_HASH: begin
            cmd.hash = 1'b1;
            if (sts.op == ACT_CLEAR) begin
               clr_req_in = 1'b1;
               state_in   = S_CLEAR;
            end else if (!sts.key_zero && (sts.op == ACT_LOOKUP || sts.op == ACT_STORE)) begin
               state_in = S_REDUCE;
            end else begin
               state_in = S_RESP;
            end
         end
         S_REDUCE: begin
            cmd.rem_step = 1'b1;
            if (sts.rem_last) begin
               cmd.slot_load = 1'b1;
               state_in      = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = S_CHECK;
         end
         S_CHECK: begin
            if (sts.op == ACT_STORE) begin
               if (sts.slot_empty || sts.key_match || sts.epoch_stale) begin
                  cmd.mem_write = 1'b1;
                  state_in      = S_RESP;
               end else if (sts.probe_last) begin
                  state_in = S_RESP;
               end else begin
                  cmd.probe_next = 1'b1;
               end
            end else begin
               if (sts.slot_empty) begin
                  state_in = S_RESP;
               end else if (sts.key_match) begin
                  cmd.res_lookup = 1'b1;
                  state_in       = S_RESP;
               end else if (sts.probe_last) begin
                  state_in = S_RESP;
               end else begin
                  cmd.probe_next = 1'b1;
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_req_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_req_ff   <= clr_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_reset_sweep: assert property (@(posedge clock)
      reset |=> state_ff == S_CLEAR)
      else $error("no clear sweep after reset");

   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_HASH)
      else $error("accepted word did not start hashing");

   a_store_slot_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_write |-> (sts.op == ACT_STORE
                         && (sts.slot_empty || sts.key_match || sts.epoch_stale)))
      else $error("slot written without a usable slot");
`endif

endmodule

@@ rtl/core/versioned_hash_memo_table.sv @@
// top level of the versioned hash memo table: controller plus datapath
//
//   channel | ports                          | word
//   --------+--------------------------------+--------------------------------------
//   request | req_valid, req_ready, req_word | action, key, version, epoch, answer
//   result  | rsp_valid, rsp_ready, rsp_word | lookup answer, store done
//
// a lookup or store runs hash, reduce and read, then checks p slots and hands off, p the
// probes walked (1 to MAX_PROBES, one slot memory read a cycle); a table size
// that is not a power of two adds 2 reduction steps (quotient, multiply back)
// a zero key or unused action goes from hash to result; a clear sweeps every slot
// after reset the table is swept over every slot, req_ready low meanwhile
// the result sits in an output register, so a stalled rsp_ready only blocks
// once the next word is finished
module versioned_hash_memo_table #(
   parameter int TABLE_SLOTS = vhmt_pkg::TABLE_SLOTS_DEF,
   parameter int MAX_PROBES  = vhmt_pkg::MAX_PROBES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vhmt_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vhmt_pkg::rsp_type rsp_word
);
   import vhmt_pkg::*;

   // command and status between the two halves
   cmd_type cmd;
   sts_type sts;

   // sequencing of sweep, hash, probe walk and handoff
   vhmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot memory, hash unit and result register
   vhmt_dpath #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .MAX_PROBES  (MAX_PROBES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_word)
   );

endmodule

@@ tb/tb_versioned_hash_memo_table.sv @@
// self-checking testbench for the versioned hash memo table
module tb_versioned_hash_memo_table;
   import vhmt_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 10;
   localparam int SLOTS         = TABLE_SLOTS_DEF;
   localparam int PROBES        = MAX_PROBES_DEF;
   // keys that differ only from this bit up share a home slot
   localparam int CHAIN_LSB     = KEY_DROP + HASH_W;
   localparam int CHAIN_GROUPS  = 6;
   localparam int PHASE_ITEMS   = 465;
   localparam int CLEAR_BUDGET  = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 2 * (5 + PROBES);
   localparam int LIMIT_CYCLES  = 2_000_000;

   // the one action code the package leaves unnamed
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // directed keys: A and B share a home slot, C homes near the table end
   localparam logic [63:0] KEY_A    = 64'h0000_0000_0000_0010;
   localparam logic [63:0] KEY_B    = 64'h0000_0010_0000_0010;
   localparam logic [63:0] KEY_C    = 64'h0000_0000_0000_7850;
   localparam logic [63:0] KEY_C_33 = 64'h0000_0200_0000_7850;
   localparam logic [63:0] KEY_ONES = 64'hffff_ffff_ffff_ffff;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key;
      logic [31:0] version;
      logic [31:0] epoch;
      logic        answer_bit;
      logic [5:0]  reps;
      logic        typed;
      logic [1:0]  want_answer;
      logic        want_done;
   } script_row_type;

   // action, key, version, epoch, bit, repeats, typed, answer, done
   // repeated rows step the key above the hash field, so all land on one chain
   localparam script_row_type SCRIPT [25] = '{
      // empty table after the reset sweep
      '{ACT_LOOKUP, KEY_A,    32'd1, 32'd1, 1'b0, 6'd1,  1'b1, ANS_UNKNOWN, 1'b0},
      // zero key is ignored by lookup and store
      '{ACT_LOOKUP, 64'd0,    32'd1, 32'd1, 1'b0, 6'd1,  1'b1, ANS_UNKNOWN, 1'b0},
      '{ACT_STORE,  64'd0,    32'd1, 32'd1, 1'b1, 6'd1,  1'b1, ANS_UNKNOWN, 1'b0},
      '{ACT_STORE,  KEY_A,    32'd1, 32'd1, 1'b1, 6'd1,  1'b1, ANS_UNKNOWN, 1'b1},
      '{ACT_LOOKUP, KEY_A,    32'd1, 32'd1, 1'b0, 6'd1,  1'b1, ANS_TRUE,    1'b0},
      // key match but version, then epoch, differs
      '{ACT_LOOKUP, KEY_A,    32'd2, 32'd1, 1'b0, 6'd1,  1'b1, ANS_UNKNOWN, 1'b0},
      '{ACT_LOOKUP, KEY_A,    32'd1, 32'd2, 1'b0, 6'd1,  1'b1, ANS_UNKNOWN, 1'b0},
      // same key rewrites its slot
      '{ACT_STORE,  KEY_A,    32'd1, 32'd1, 1'b0, 6'd1,  1'b1, ANS_UNKNOWN, 1'b1},
      '{ACT_LOOKUP, KEY_A,    32'd1, 32'd1, 1'b0, 6'd1,  1'b1, ANS_FALSE,   1'b0},
      '{ACT_UNUSED, KEY_A,    32'd1, 32'd1, 1'b1, 6'd1,  1'b1, ANS_UNKNOWN, 1'b0},
      // all-ones extremes
      '{ACT_STORE,  KEY_ONES, '1,    '1,    1'b1, 6'd1,  1'b1, ANS_UNKNOWN, 1'b1},
      '{ACT_LOOKUP, KEY_ONES, '1,    '1,    1'b0, 6'd1,  1'b1, ANS_TRUE,    1'b0},
      // collision, then a store in a new epoch takes over the stale home slot
      '{ACT_STORE,  KEY_B,    32'd1, 32'd1, 1'b0, 6'd1,  1'b0, ANS_UNKNOWN, 1'b0},
      '{ACT_STORE,  KEY_B,    32'd1, 32'd2, 1'b1, 6'd1,  1'b0, ANS_UNKNOWN, 1'b0},
      '{ACT_LOOKUP, KEY_B,    32'd1, 32'd2, 1'b0, 6'd1,  1'b0, ANS_UNKNOWN, 1'b0},
      '{ACT_LOOKUP, KEY_A,    32'd1, 32'd1, 1'b0, 6'd1,  1'b0, ANS_UNKNOWN, 1'b0},
      // clear ignores its key and empties everything
      '{ACT_CLEAR,  KEY_ONES, '1,    '1,    1'b1, 6'd1,  1'b1, ANS_UNKNOWN, 1'b0},
      '{ACT_LOOKUP, KEY_ONES, '1,    '1,    1'b0, 6'd1,  1'b1, ANS_UNKNOWN, 1'b0},
      // one chain past the probe limit, wrapping at the table end
      '{ACT_STORE,  KEY_C,    32'd5, 32'd3, 1'b1, 6'd33, 1'b0, ANS_UNKNOWN, 1'b0},
      '{ACT_LOOKUP, KEY_C,    32'd5, 32'd3, 1'b0, 6'd2,  1'b0, ANS_UNKNOWN, 1'b0},
      '{ACT_LOOKUP, KEY_C_33, 32'd5, 32'd3, 1'b0, 6'd1,  1'b0, ANS_UNKNOWN, 1'b0},
      '{ACT_LOOKUP, KEY_C | 64'd1, 32'd5, 32'd3, 1'b0, 6'd1, 1'b0, ANS_UNKNOWN, 1'b0},
      // slot zero, holding part of the wrapped chain, goes stale under epoch 0
      '{ACT_STORE,  64'd1,    32'd0, 32'd0, 1'b0, 6'd1,  1'b0, ANS_UNKNOWN, 1'b0},
      '{ACT_LOOKUP, 64'd1,    32'd0, 32'd0, 1'b0, 6'd1,  1'b0, ANS_UNKNOWN, 1'b0},
      '{ACT_CLEAR,  64'd0,    32'd0, 32'd0, 1'b0, 6'd1,  1'b1, ANS_UNKNOWN, 1'b0}
   };

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_word;

   // predicted table contents
   bit [63:0] memo_key     [SLOTS];
   bit [31:0] memo_epoch   [SLOTS];
   bit [31:0] memo_version [SLOTS];
   bit        memo_answer  [SLOTS];

   // answers still owed by the block, oldest first
   rsp_type answers_due [$];

   logic [63:0] chain_base [CHAIN_GROUPS];

   int mismatch_count = 0;
   int words_checked  = 0;
   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   // bumped by the stimulus to ask the receiver for a long hold-off
   int rsp_hold_req   = 0;

   versioned_hash_memo_table u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always #HALF_PERIOD clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // applies one request word to the predicted table, returns its answer word
   function automatic rsp_type memo_predict(input req_type w);
      rsp_type     r;
      logic [31:0] hash;
      int unsigned s;
      r    = '0;
      hash = w.item_key[KEY_DROP +: HASH_W] * HASH_MUL;
      s    = hash % SLOTS;
      case (w.action)
         ACT_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               memo_key[i]     = '0;
               memo_epoch[i]   = '0;
               memo_version[i] = '0;
               memo_answer[i]  = 1'b0;
            end
         end
         ACT_LOOKUP: begin
            if (w.item_key != '0) begin
               for (int p = 0; p < PROBES; p++) begin
                  // empty slot ends the chain
                  if (memo_key[s] == '0) break;
                  if (memo_key[s] == w.item_key) begin
                     // a hit only counts when epoch and version both agree
                     if (memo_epoch[s] == w.current_epoch &&
                         memo_version[s] == w.item_version) begin
                        r.lookup_answer = memo_answer[s] ? ANS_TRUE : ANS_FALSE;
                     end
                     break;
                  end
                  s = (s + 1) % SLOTS;
               end
            end
         end
         ACT_STORE: begin
            if (w.item_key != '0) begin
               for (int p = 0; p < PROBES; p++) begin
                  // empty, same key or stale epoch: take this slot
                  if (memo_key[s] == '0 || memo_key[s] == w.item_key ||
                      memo_epoch[s] != w.current_epoch) begin
                     memo_key[s]     = w.item_key;
                     memo_epoch[s]   = w.current_epoch;
                     memo_version[s] = w.item_version;
                     memo_answer[s]  = w.answer_bit;
                     r.store_done    = 1'b1;
                     break;
                  end
                  s = (s + 1) % SLOTS;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // offers one word with random gaps, then books its answer once accepted
   task automatic offer_word(input req_type w, input bit typed, input rsp_type want);
      rsp_type due;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      // the predictor always runs so its table keeps in step
      due = memo_predict(w);
      answers_due.push_back(typed ? want : due);
   endtask

   // receiver: checks every accepted answer word and drives rsp_ready
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("answer word %0d with nothing owed: %h",
                                         words_checked, rsp_word));
            end else begin
               rsp_type want;
               want = answers_due.pop_front();
               if (rsp_word.lookup_answer !== want.lookup_answer) begin
                  report_mismatch($sformatf("word %0d lookup_answer got %0d want %0d",
                                            words_checked, rsp_word.lookup_answer,
                                            want.lookup_answer));
               end
               if (rsp_word.store_done !== want.store_done) begin
                  report_mismatch($sformatf("word %0d store_done got %0d want %0d",
                                            words_checked, rsp_word.store_done,
                                            want.store_done));
               end
            end
         end
         // long hold-off: the block fills up and drops req_ready
         if (hold_seen != rsp_hold_req) begin
            hold_seen = rsp_hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // stimulus
   initial begin
      req_type     w;
      req_type     last_store;
      rsp_type     want;
      int          sel;
      int          counted;
      int          clears_left;
      logic [31:0] live_epoch;

      last_store  = '0;
      clears_left = CLEAR_BUDGET;
      live_epoch  = 32'd1;
      // group 0 homes near the table end so its chains wrap
      chain_base[0] = KEY_C;
      for (int g = 1; g < CHAIN_GROUPS; g++) begin
         chain_base[g] = {28'd0, 32'($urandom), 4'd0};
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part, under the first idling mix
      req_idle_pct = 25;
      rsp_idle_pct <= 47;
      foreach (SCRIPT[i]) begin
         for (int rep = 0; rep < SCRIPT[i].reps; rep++) begin
            w.action        = SCRIPT[i].action;
            w.item_key      = SCRIPT[i].key + (64'(rep) << CHAIN_LSB);
            w.item_version  = SCRIPT[i].version;
            w.current_epoch = SCRIPT[i].epoch;
            w.answer_bit    = SCRIPT[i].answer_bit;
            want.lookup_answer = SCRIPT[i].want_answer;
            want.store_done    = SCRIPT[i].want_done;
            offer_word(w, SCRIPT[i].typed, want);
         end
      end

      // random part in three idling mixes
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 25;
               rsp_idle_pct <= 47;
            end
            1: begin
               req_idle_pct = 47;
               rsp_idle_pct <= 25;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct <= 0;
               rsp_hold_req <= rsp_hold_req + 1;
            end
         endcase
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            sel = $urandom_range(0, 199);
            if (sel < 2 && clears_left > 0) begin
               w.action = ACT_CLEAR;
               clears_left--;
            end else if (sel < 8) begin
               w.action = ACT_UNUSED;
            end else if (sel < 104) begin
               w.action = ACT_LOOKUP;
            end else begin
               w.action = ACT_STORE;
            end

            // keys: mostly long collision chains, some zero, some anywhere
            sel = $urandom_range(0, 99);
            if (sel < 4) begin
               w.item_key = '0;
            end else if (sel < 22) begin
               w.item_key = {$urandom, $urandom};
            end else begin
               w.item_key = chain_base[$urandom_range(0, CHAIN_GROUPS - 1)];
               w.item_key[63:CHAIN_LSB] = 28'($urandom_range(0, 39));
               if ($urandom_range(0, 1)) begin
                  w.item_key[KEY_DROP-1:0] = 4'($urandom_range(0, 15));
               end
            end

            // epoch drifts over a few values so stale slots appear
            if ($urandom_range(0, 99) < 3) live_epoch = $urandom_range(0, 5);
            sel = $urandom_range(0, 99);
            w.current_epoch = (sel < 85) ? live_epoch :
                              (sel < 92) ? live_epoch + 32'd1 : 32'($urandom);
            w.item_version  = ($urandom_range(0, 99) < 80) ?
                              32'($urandom_range(0, 3)) : 32'($urandom);
            w.answer_bit    = 1'($urandom_range(0, 1));

            // many lookups ask for the last thing stored, to get real hits
            if (w.action == ACT_LOOKUP && $urandom_range(0, 99) < 30) begin
               w.item_key      = last_store.item_key;
               w.item_version  = last_store.item_version;
               w.current_epoch = last_store.current_epoch;
            end
            if (w.action == ACT_STORE) last_store = w;

            // ignored words do not count toward the phase
            if (w.action == ACT_CLEAR ||
                (w.action != ACT_UNUSED && w.item_key != '0)) begin
               counted++;
            end
            offer_word(w, 1'b0, '0);
         end

         // sender pauses until every owed answer is back
         req_valid <= 1'b0;
         do @(posedge clock); while (answers_due.size() != 0);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && answers_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
